// ===== design/route_longest_prefix_match_top_defines.svh =====
// ----------------------------------------------------------------------------
// route_longest_prefix_match_top_defines.svh
// assertion macros for the route lookup checker
// ----------------------------------------------------------------------------
`ifndef ROUTE_LONGEST_PREFIX_MATCH_TOP_DEFINES_SVH
`define ROUTE_LONGEST_PREFIX_MATCH_TOP_DEFINES_SVH

// concurrent assertion on a given clock and reset
`define RLPM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define RLPM_ASSERT_CLK(label, prop, msg) \
   `RLPM_ASSERT(label, clock, reset, prop, msg)

`endif

// ===== design/lpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_pkg
// shared types and constants of the longest prefix match route table
// ----------------------------------------------------------------------------
package lpm_pkg;

   // default table size
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   // field widths
   localparam int ADDR_W  = 32;
   localparam int PORT_W  = 4;
   localparam int INDEX_W = 10;
   localparam int COUNT_W = 11;

   // stream word widths
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 40;

   // request opcodes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // one stored route
   typedef struct packed {
      logic [ADDR_W-1:0] prefix;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] gateway;
      logic [PORT_W-1:0] port;
   } lpm_entry_type;

   // lookup sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } lpm_state_type;

endpackage

// ===== design/lpm_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_table
// route entry memory, one write port and one read port with registered data
// ----------------------------------------------------------------------------
module lpm_table
   import lpm_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int SLOT_W = $clog2(TABLE_DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [SLOT_W-1:0]   wr_addr,
   input  lpm_entry_type       wr_data,
   input  logic                rd_en,
   input  logic [SLOT_W-1:0]   rd_addr,
   output lpm_entry_type       rd_data
);

   lpm_entry_type mem [TABLE_DEPTH];
   lpm_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/route_longest_prefix_match_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_longest_prefix_match_top
// route table with longest prefix match lookup
//
//   channel  dir  handshake            contents
//   req_*    in   req_tvalid/tready    tuser opcode, tdata route entry / dest
//   rsp_*    out  rsp_tvalid/tready    tuser hit, tdata next hop and port
//   csr_*    in   csr_wr_en            route_count
//
// a write word gives no response
// a lookup scans route_count entries (count capped at TABLE_DEPTH),
// then passes a drain state to the done state, or goes straight to done at zero:
// the scan reads one entry per cycle through the single table read port
// synchronous reset clears control; table contents are undefined until written
// the next word is taken once a lookup result sits in the output register
// ----------------------------------------------------------------------------
module route_longest_prefix_match_top
   import lpm_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // entry_index, entry_prefix, entry_mask, entry next-hop address, entry_port,
   // dest_addr, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic                  req_tuser,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // next-hop address, out_port, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // hit
   output logic                  rsp_tuser,
   // configuration
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data
);

   localparam int SLOT_W = $clog2(TABLE_DEPTH);
   localparam int LIM_W  = $clog2(TABLE_DEPTH + 1);

   // request fields
   logic [INDEX_W-1:0] entry_index;
   lpm_entry_type      entry_wr;
   logic [ADDR_W-1:0]  dest_addr;

   assign entry_index       = req_tdata[9:0];
   assign entry_wr.prefix   = req_tdata[41:10];
   assign entry_wr.mask     = req_tdata[73:42];
   assign entry_wr.gateway  = req_tdata[105:74];
   assign entry_wr.port     = req_tdata[109:106];
   assign dest_addr         = req_tdata[141:110];

   // control and state
   lpm_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] route_count_ff;
   logic [ADDR_W-1:0]  dest_ff;
   logic [SLOT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [SLOT_W-1:0]  last_idx_ff;
   logic               rd_vld_ff;
   logic               found_ff;
   logic [ADDR_W-1:0]  best_mask_ff;
   logic [ADDR_W-1:0]  best_nh_ff;
   logic [PORT_W-1:0]  best_port_ff;
   logic               out_vld_ff;
   logic               out_hit_ff;
   logic [ADDR_W-1:0]  out_nh_ff;
   logic [PORT_W-1:0]  out_port_ff;

   logic               req_acc;
   logic               is_lookup;
   logic               wr_en;
   logic               issue_rd;
   logic               load_out;
   logic               idle;
   logic [LIM_W-1:0]   limit;
   logic               limit_zero;
   lpm_entry_type      rd_entry;
   logic               entry_match;
   logic               entry_better;

   assign req_acc   = req_tvalid && req_tready;
   assign is_lookup = (req_tuser == OP_LOOKUP);

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         route_count_ff <= '0;
      end else if (csr_wr_en) begin
         route_count_ff <= csr_wr_data;
      end
   end

   // search limit, capped at the table size
   always_comb begin
      if (32'(route_count_ff) > 32'(TABLE_DEPTH)) begin
         limit = LIM_W'(TABLE_DEPTH);
      end else begin
         limit = LIM_W'(route_count_ff);
      end
      limit_zero = (limit == '0);
   end

   // table write, out of range slots dropped
   assign wr_en = req_acc && (req_tuser == OP_WRITE)
                  && (32'(entry_index) < 32'(TABLE_DEPTH));

   lpm_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_lpm_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (SLOT_W'(entry_index)),
      .wr_data (entry_wr),
      .rd_en   (issue_rd),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_entry)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && is_lookup) begin
               state_in = limit_zero ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff == last_idx_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_vld_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      idle     = 1'b0;
      issue_rd = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE:  idle = 1'b1;
         ST_SCAN:  issue_rd = 1'b1;
         ST_DRAIN: ;
         ST_DONE:  load_out = !out_vld_ff || rsp_tready;
         default:  ;
      endcase
   end

   assign req_tready = idle;
   assign rd_idx_in  = issue_rd ? rd_idx_ff + 1'b1 : rd_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue_rd;
      end
   end

   // scan pointer and lookup key
   always_ff @(posedge clock) begin
      if (req_acc && is_lookup) begin
         dest_ff     <= dest_addr;
         rd_idx_ff   <= '0;
         last_idx_ff <= SLOT_W'(limit - 1'b1);
      end else begin
         rd_idx_ff   <= rd_idx_in;
      end
   end

   // compare stage on the read data
   assign entry_match  = ((dest_ff & rd_entry.mask) == rd_entry.prefix);
   assign entry_better = !found_ff || (rd_entry.mask > best_mask_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (req_acc && is_lookup) begin
         found_ff <= 1'b0;
      end else if (rd_vld_ff && entry_match && entry_better) begin
         found_ff <= 1'b1;
      end
   end

   // best entry so far, strict compare keeps the lowest index on ties
   always_ff @(posedge clock) begin
      if (rd_vld_ff && entry_match && entry_better) begin
         best_mask_ff <= rd_entry.mask;
         best_nh_ff   <= rd_entry.gateway;
         best_port_ff <= rd_entry.port;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (load_out) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_hit_ff  <= found_ff;
         out_nh_ff   <= found_ff ? best_nh_ff : '0;
         out_port_ff <= found_ff ? best_port_ff : '0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ADDR_W - PORT_W){1'b0}}, out_port_ff, out_nh_ff};

endmodule

// ===== design/lpm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpm_checker
// port level checks of the route lookup block, bound to the top level
// ----------------------------------------------------------------------------
`include "route_longest_prefix_match_top_defines.svh"

module lpm_checker
   import lpm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   // a stalled response holds its word
   `RLPM_ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")

   // a miss carries a zero next hop and port
   `RLPM_ASSERT_CLK(a_miss_zero, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0, "miss with nonzero payload")

   // a table write never raises a response
   `RLPM_ASSERT_CLK(a_write_silent, req_tvalid && req_tready && req_tuser == OP_WRITE |=> !$rose(rsp_tvalid), "response after a table write")

   // a lookup holds off the request side while it scans
   `RLPM_ASSERT(a_lookup_busy, clock, reset, req_tvalid && req_tready && req_tuser == OP_LOOKUP |=> !req_tready, "request taken during a lookup")

endmodule

bind route_longest_prefix_match_top lpm_checker u_lpm_checker (.*);
